FILE: sv/eeg_pkg.sv
// Package with shared types for the extended Euclid GCD block.
`timescale 1ns / 1ps
package eeg_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture operands and start values
    logic div_start; // begin one quotient division
    logic mul_start; // begin the multiply-subtract pass
    logic fix_sign;  // negate results when old_r is negative
  } eeg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic r_zero;   // current remainder is zero
    logic div_done; // quotient ready
    logic mul_done; // updates written back
  } eeg_sts_t;

endpackage

FILE: sv/extended_euclid_gcd.sv
// Top level of the extended Euclid GCD block: stream ports, controller, datapath.
`timescale 1ns / 1ps
// Computes g = gcd(a, b) and Bezout coefficients x, y with a*x + b*y = g using
// the Euclidean recurrence with quotients truncated toward zero; results are
// wrapped at DATA_WIDTH bits, negated together when the final remainder is
// negative, and sign-extended to 64 bits. a = b = 0 gives g = 0, x = 1, y = 0.
// One request is processed at a time. Each Euclid step runs a test, a
// bit-serial division and a shift-add multiply-subtract pass; the number
// of steps is at most about 92 for 64-bit operands.
// in_tready is high only while the block is idle; the result is held on
// out_tdata until it is taken.
module extended_euclid_gcd
  import eeg_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // operand_a [63:0], operand_b [127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata   // divisor [63:0], coeff_a [127:64], coeff_b [191:128]
);

  eeg_cmd_t cmd;
  eeg_sts_t sts;
  logic     idle, res_valid, in_fire, out_fire;
  logic [DATA_WIDTH-1:0] g, x, y;

  assign in_tready  = idle;
  assign in_fire    = in_tvalid && idle;
  assign out_tvalid = res_valid;
  assign out_fire   = res_valid && out_tready;

  eeg_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd, .idle, .res_valid
  );

  // only the low DATA_WIDTH bits of each operand take part
  eeg_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .a_in (in_tdata[DATA_WIDTH-1:0]),
    .b_in (in_tdata[64 +: DATA_WIDTH]),
    .g_out(g), .x_out(x), .y_out(y)
  );

  // sign-extend each result to 64 bits
  assign out_tdata = {64'(signed'(y)), 64'(signed'(x)), 64'(signed'(g))};

endmodule

FILE: sv/eeg_datapath.sv
// Datapath: remainder/coefficient registers, serial divider, serial multiply-subtract.
`timescale 1ns / 1ps
module eeg_datapath
  import eeg_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  eeg_cmd_t              cmd,
  output eeg_sts_t              sts,
  input  logic [DATA_WIDTH-1:0] a_in,
  input  logic [DATA_WIDTH-1:0] b_in,
  output logic [DATA_WIDTH-1:0] g_out,
  output logic [DATA_WIDTH-1:0] x_out,
  output logic [DATA_WIDTH-1:0] y_out
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] old_r_r, r_r, old_s_r, s_r, old_t_r, t_r;
  logic [DATA_WIDTH-1:0] old_r_nxt, r_nxt, old_s_nxt, s_nxt, old_t_nxt, t_nxt;

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [DATA_WIDTH-1:0] dq_r, dq_nxt, dd_r, dd_nxt;
  logic [DATA_WIDTH:0]   rem_r, rem_nxt, rem_sh, rem_sub;
  logic                  qneg_r, qneg_nxt, dbusy_r, dbusy_nxt;
  logic [CW-1:0]         dcnt_r, dcnt_nxt;

  // Shift-add multipliers: q times r, s, t, one multiplier bit per cycle.
  logic [DATA_WIDTH-1:0] q_r, q_nxt, mr_r, mr_nxt, ms_r, ms_nxt, mt_r, mt_nxt;
  logic [DATA_WIDTH-1:0] pr_r, pr_nxt, ps_r, ps_nxt, pt_r, pt_nxt;
  logic                  mbusy_r, mbusy_nxt;
  logic [CW-1:0]         mcnt_r, mcnt_nxt;

  logic                  div_done_r, div_done_nxt, mul_done_r, mul_done_nxt;
  logic [DATA_WIDTH-1:0] qmag;

  assign rem_sh  = {rem_r[DATA_WIDTH-1:0], dq_r[DATA_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, dd_r};
  assign qmag    = dq_r;

  always_comb begin
    old_r_nxt = old_r_r; r_nxt = r_r; old_s_nxt = old_s_r; s_nxt = s_r;
    old_t_nxt = old_t_r; t_nxt = t_r;
    dq_nxt = dq_r; dd_nxt = dd_r; rem_nxt = rem_r; qneg_nxt = qneg_r;
    dbusy_nxt = dbusy_r; dcnt_nxt = dcnt_r; div_done_nxt = 1'b0;
    q_nxt = q_r; mr_nxt = mr_r; ms_nxt = ms_r; mt_nxt = mt_r;
    pr_nxt = pr_r; ps_nxt = ps_r; pt_nxt = pt_r;
    mbusy_nxt = mbusy_r; mcnt_nxt = mcnt_r; mul_done_nxt = 1'b0;

    if (cmd.load) begin
      old_r_nxt = a_in; r_nxt = b_in;
      old_s_nxt = DATA_WIDTH'(1); s_nxt = '0;
      old_t_nxt = '0; t_nxt = DATA_WIDTH'(1);
    end

    if (cmd.fix_sign && old_r_r[DATA_WIDTH-1]) begin
      old_r_nxt = -old_r_r; old_s_nxt = -old_s_r; old_t_nxt = -old_t_r;
    end

    if (cmd.div_start) begin
      dq_nxt    = old_r_r[DATA_WIDTH-1] ? -old_r_r : old_r_r;
      dd_nxt    = r_r[DATA_WIDTH-1] ? -r_r : r_r;
      qneg_nxt  = old_r_r[DATA_WIDTH-1] ^ r_r[DATA_WIDTH-1];
      rem_nxt   = '0;
      dcnt_nxt  = CW'(DATA_WIDTH);
      dbusy_nxt = 1'b1;
    end else if (dbusy_r) begin
      if (!rem_sub[DATA_WIDTH]) begin
        rem_nxt = rem_sub;
        dq_nxt  = {dq_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dq_nxt  = {dq_r[DATA_WIDTH-2:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - CW'(1);
      if (dcnt_r == CW'(1)) begin
        dbusy_nxt = 1'b0; div_done_nxt = 1'b1;
      end
    end

    if (cmd.mul_start) begin
      q_nxt  = qneg_r ? -qmag : qmag;
      mr_nxt = r_r; ms_nxt = s_r; mt_nxt = t_r;
      pr_nxt = '0; ps_nxt = '0; pt_nxt = '0;
      mcnt_nxt  = CW'(DATA_WIDTH);
      mbusy_nxt = 1'b1;
    end else if (mbusy_r) begin
      if (q_r[0]) begin
        pr_nxt = pr_r + mr_r; ps_nxt = ps_r + ms_r; pt_nxt = pt_r + mt_r;
      end
      q_nxt  = q_r >> 1;
      mr_nxt = mr_r << 1; ms_nxt = ms_r << 1; mt_nxt = mt_r << 1;
      mcnt_nxt = mcnt_r - CW'(1);
      if (mcnt_r == CW'(1)) begin
        mbusy_nxt = 1'b0; mul_done_nxt = 1'b1;
        // advance the recurrence: old <- cur, cur <- old - q*cur
        old_r_nxt = r_r; r_nxt = old_r_r - pr_nxt;
        old_s_nxt = s_r; s_nxt = old_s_r - ps_nxt;
        old_t_nxt = t_r; t_nxt = old_t_r - pt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; mbusy_r <= 1'b0;
      div_done_r <= 1'b0; mul_done_r <= 1'b0;
      dcnt_r <= '0; mcnt_r <= '0;
    end else begin
      dbusy_r <= dbusy_nxt; mbusy_r <= mbusy_nxt;
      div_done_r <= div_done_nxt; mul_done_r <= mul_done_nxt;
      dcnt_r <= dcnt_nxt; mcnt_r <= mcnt_nxt;
    end
    old_r_r <= old_r_nxt; r_r <= r_nxt; old_s_r <= old_s_nxt; s_r <= s_nxt;
    old_t_r <= old_t_nxt; t_r <= t_nxt;
    dq_r <= dq_nxt; dd_r <= dd_nxt; rem_r <= rem_nxt; qneg_r <= qneg_nxt;
    q_r <= q_nxt; mr_r <= mr_nxt; ms_r <= ms_nxt; mt_r <= mt_nxt;
    pr_r <= pr_nxt; ps_r <= ps_nxt; pt_r <= pt_nxt;
  end

  assign sts.r_zero   = (r_r == '0);
  assign sts.div_done = div_done_r;
  assign sts.mul_done = mul_done_r;
  assign g_out = old_r_r;
  assign x_out = old_s_r;
  assign y_out = old_t_r;

`ifndef SYNTH
  a_not_both_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(dbusy_r && mbusy_r)) else $error("divider and multiplier overlap");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> dbusy_r && dcnt_r == CW'(DATA_WIDTH))
    else $error("divider did not start");
  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dbusy_r |-> rem_r < {1'b0, dd_r}) else $error("partial remainder too large");
`endif

endmodule

FILE: sv/eeg_ctrl.sv
// Controller state machine sequencing the Euclid iterations.
`timescale 1ns / 1ps
module eeg_ctrl
  import eeg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  eeg_sts_t sts,
  output eeg_cmd_t cmd,
  output logic     idle,
  output logic     res_valid
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TEST = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1; state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.r_zero) begin
          state_nxt = ST_FIX;
        end else begin
          cmd.div_start = 1'b1; state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.mul_start = 1'b1; state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts.mul_done) state_nxt = ST_TEST;
      end
      ST_FIX: begin
        cmd.fix_sign = 1'b1; state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_OUT);

`ifndef SYNTH
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == ST_IDLE) else $error("request taken while busy");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_fire |=> res_valid) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("overlapping commands");
`endif

endmodule

FILE: sim/extended_euclid_gcd_tb.sv
// Self-checking testbench for the extended Euclid GCD block.
`timescale 1ns / 1ps
module extended_euclid_gcd_tb;

  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned RANDOM_REQUESTS = 80;
  localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] coeff_b;
    logic [63:0] coeff_a;
    logic [63:0] divisor;
  } bezout_t;

  // Bezout predictor plus queue of pending results.
  class bezout_board;
    bezout_t pending_q[$];
    int unsigned errors;
    int unsigned checked;

    // Run the truncating Euclid recurrence with 64-bit wrap.
    function bezout_t predict(logic [63:0] a, logic [63:0] b);
      logic signed [63:0] old_r, r, old_s, s, old_t, t, q, tmp;
      bezout_t res;
      old_r = a;
      r = b;
      old_s = 1;
      s = 0;
      old_t = 0;
      t = 1;
      while (r != 0) begin
        // most negative divided by minus one wraps
        if (r == -64'sd1) q = -old_r;
        else q = old_r / r;
        tmp = old_r - q * r; old_r = r; r = tmp;
        tmp = old_s - q * s; old_s = s; s = tmp;
        tmp = old_t - q * t; old_t = t; t = tmp;
      end
      if (old_r < 0) begin
        old_r = -old_r;
        old_s = -old_s;
        old_t = -old_t;
      end
      res.divisor = old_r;
      res.coeff_a = old_s;
      res.coeff_b = old_t;
      return res;
    endfunction

    function void note_request(logic [63:0] a, logic [63:0] b);
      pending_q = {pending_q, predict(a, b)};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(want));
    endtask

    task check_result(bezout_t got);
      bezout_t want;
      checked++;
      if (pending_q.size() == 0) begin
        report("result with no request outstanding", got.divisor, '0);
        return;
      end
      want = pending_q.pop_front();
      if (got.divisor !== want.divisor) report("divisor", got.divisor, want.divisor);
      if (got.coeff_a !== want.coeff_a) report("coeff_a", got.coeff_a, want.coeff_a);
      if (got.coeff_b !== want.coeff_b) report("coeff_b", got.coeff_b, want.coeff_b);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [127:0] in_tdata;   // operand_a [63:0], operand_b [127:64]
  logic out_tvalid;
  logic out_tready;
  logic [191:0] out_tdata;  // divisor [63:0], coeff_a [127:64], coeff_b [191:128]

  bezout_board board;
  bit stall_enable;
  bit drain_done;
  int unsigned idle_cycles;
  int unsigned sent;
  int unsigned out_hold;

  extended_euclid_gcd i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Send one request and hold it until accepted; valid stays high between
  // back-to-back requests and drops only for an idle burst.
  task automatic send_request(logic [63:0] a, logic [63:0] b);
    int unsigned gap;
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    do @(posedge clk); while (!in_tready);
    board.note_request(a, b);
    sent++;
  endtask

  // Random operand: mostly small magnitudes so the run stays short,
  // with some full-width values and extremes.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = {$urandom, $urandom};
      1: v = $urandom_range(0, 1) ? MIN_VAL : MAX_VAL;
      2, 3: v = $urandom_range(0, 1000);
      default: v = $urandom_range(0, 1 << 20);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Result side: take results, stall at random in bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else if (out_hold != 0) begin
      out_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (stall_enable && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      out_hold <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !drain_done) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("extended_euclid_gcd verification failed");
      $finish;
    end
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    stall_enable = 1'b1;
    drain_done = 1'b0;
    idle_cycles = 0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros, extremes, most negative over minus one, sign cases.
    send_request(64'd0, 64'd0);
    send_request(64'd0, 64'd7);
    send_request(64'd9, 64'd0);
    send_request(-64'd9, 64'd0);
    send_request(64'd0, -64'd5);
    send_request(MIN_VAL, -64'd1);
    send_request(-64'd1, MIN_VAL);
    send_request(MIN_VAL, 64'd0);
    send_request(MIN_VAL, MIN_VAL);
    send_request(MAX_VAL, MIN_VAL);
    send_request(MAX_VAL, MAX_VAL);
    send_request(MAX_VAL, 64'd1);
    send_request(64'd240, 64'd46);
    send_request(-64'd240, 64'd46);
    send_request(64'd240, -64'd46);
    send_request(-64'd240, -64'd46);
    send_request(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    // consecutive Fibonacci numbers give the longest loop
    send_request(64'd7540113804746346429, 64'd4660046610375530309);
    send_request(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_request(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    in_tvalid <= 1'b0;

    // Hold off until every outstanding result has come back.
    while (board.pending_q.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS - 20) stall_enable = 1'b0;
      send_request(rand_operand(), rand_operand());
    end
    in_tvalid <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    drain_done = 1'b1;

    $display("Sent %0d requests (zero, extreme, wrap and random operands),", sent);
    $display("checked %0d results with random stalls on both sides.", board.checked);
    if (board.errors == 0) begin
      $display("extended_euclid_gcd verification clean");
    end else begin
      $display("extended_euclid_gcd verification failed");
    end
    $finish;
  end

endmodule

FILE: extended_euclid_gcd.f
sv/eeg_pkg.sv
sv/eeg_datapath.sv
sv/eeg_ctrl.sv
sv/extended_euclid_gcd.sv
sim/extended_euclid_gcd_tb.sv
